>>> rtl/core/water_ripple_grid_step_macros.svh
// Assertion macros shared by the checker files of the water ripple block.
// Each macro expands to one labeled concurrent assertion with async reset.
`ifndef WATER_RIPPLE_GRID_STEP_MACROS_SVH
`define WATER_RIPPLE_GRID_STEP_MACROS_SVH

// Implication in the same cycle.
`define WRGS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("water ripple assertion failed");

// Implication in the next cycle.
`define WRGS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("water ripple assertion failed");

`endif

>>> rtl/core/wrgs_pkg.sv
// Package of the water ripple grid block: sizes, action and register codes, helpers.
// Used by the interfaces, the grid RAM, the top level and the checker.
`default_nettype none

package wrgs_pkg;

	localparam int GRID_SIZE = 256;
	localparam int FRACTION_BITS = 8;
	localparam int COORD_W = $clog2(GRID_SIZE);
	localparam int ADDR_W = 2 * COORD_W;
	localparam int CELLS = GRID_SIZE * GRID_SIZE;
	localparam int H_W = 20;
	localparam int SHIFT_W = 4;
	localparam int LIMIT_W = 19;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W = H_W + 2;
	localparam int WIDE_W = H_W + 3;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(5);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50 << FRACTION_BITS);
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);
	localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(CELLS - 1);

	typedef logic [1:0] action_t;
	localparam action_t ACT_STEP = 2'd0;
	localparam action_t ACT_INJECT = 2'd1;
	localparam action_t ACT_READ = 2'd2;
	localparam action_t ACT_NONE = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_DAMPING_SHIFT = 2'd0;
	localparam cfg_idx_t REG_VISIBLE_LIMIT = 2'd1;

	typedef logic signed [H_W-1:0] height_t;

	function automatic height_t sat_height(input logic signed [WIDE_W-1:0] v);
		height_t r;
		if (v > WIDE_W'(signed'(H_W'({1'b0, {(H_W-1){1'b1}}})))) begin
			r = {1'b0, {(H_W-1){1'b1}}};
		end else if (v < WIDE_W'(signed'(H_W'({1'b1, {(H_W-1){1'b0}}})))) begin
			r = {1'b1, {(H_W-1){1'b0}}};
		end else begin
			r = v[H_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/wrgs_in_if.sv
// Channel interfaces of the water ripple block: input items, results and register writes.
// Depends on wrgs_pkg for field widths.
`default_nettype none

interface wrgs_in_if import wrgs_pkg::*; ();
	logic valid;
	logic ready;
	action_t action;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	height_t amount;
	modport source (output valid, action, col, row, amount, input ready);
	modport sink (input valid, action, col, row, amount, output ready);
endinterface

interface wrgs_out_if import wrgs_pkg::*; ();
	logic valid;
	logic ready;
	height_t height;
	logic visible;
	logic done_res;
	modport source (output valid, height, visible, done_res, input ready);
	modport sink (input valid, height, visible, done_res, output ready);
endinterface

interface wrgs_cfg_if import wrgs_pkg::*; ();
	logic valid;
	logic ready;
	cfg_idx_t index;
	logic [LIMIT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wrgs_ram.sv
// One height grid: synchronous RAM with one write port and one registered read port.
// Depends on wrgs_pkg for depth and width.
`default_nettype none

module wrgs_ram import wrgs_pkg::*; (
	input wire logic clk,
	input wire logic we,
	input wire logic [ADDR_W-1:0] waddr,
	input wire height_t wdata,
	input wire logic [ADDR_W-1:0] raddr,
	output height_t rdata
);

	height_t mem [CELLS];
	height_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/water_ripple_grid_step.sv
// Top level of the water ripple block: two grid RAMs, step sequencer, inject and read.
// Depends on wrgs_pkg, the channel interfaces and wrgs_ram.
//
// Usage: items arrive on in_ch, one result beat per item leaves on out_ch, and
// register writes arrive on cfg, which is always ready and takes effect at once.
// After reset both grids are swept to zero, one cell per cycle, over all 65536 cells;
// in_ch is not ready during that sweep.
// A read or an inject goes through ST_MEM before its result beat, since the read port
// of the grid RAM is registered. A step works through each cell in phases, since the
// four neighbors are fetched one after another through the single read port of
// the current grid, and gives its result beat after the last cell.
// The unused action code gives its result beat in the cycle after acceptance.
// One item is in work at a time. A result waits in the output register while
// out_ch is stalled, and no new item is accepted until that register is free or
// being emptied in the same cycle.
`default_nettype none

module water_ripple_grid_step import wrgs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	wrgs_in_if.sink in_ch,
	wrgs_out_if.source out_ch,
	wrgs_cfg_if.sink cfg
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_STEP = 4'b0100,
		ST_MEM = 4'b1000
	} state_t;

	state_t state_q;
	logic sel_q;
	logic [ADDR_W-1:0] idx_q;
	logic [2:0] phase_q;
	logic take_s1;
	logic signed [ACC_W-1:0] acc_q;
	height_t old_q;
	action_t act_q;
	logic [ADDR_W-1:0] addr_q;
	height_t amount_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [LIMIT_W-1:0] limit_q;
	logic out_valid_q;
	height_t out_height_q;
	logic out_visible_q;
	logic out_done_q;

	logic in_acc;
	logic out_free;
	logic [COORD_W-1:0] row_c;
	logic [COORD_W-1:0] col_c;
	logic [ADDR_W-1:0] nb_addr;
	logic nb_ok;
	logic [ADDR_W-1:0] cur_raddr;
	logic cur_we;
	logic [ADDR_W-1:0] cur_waddr;
	height_t cur_wdata;
	logic old_we;
	logic [ADDR_W-1:0] old_waddr;
	height_t old_wdata;
	height_t a_rdata;
	height_t b_rdata;
	height_t cur_rdata;
	height_t old_rdata;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] sum_w;
	logic signed [ACC_W-1:0] half_w;
	logic signed [ACC_W-1:0] n_w;
	logic signed [WIDE_W-1:0] nd_w;
	height_t step_val;
	height_t inj_val;
	logic [H_W:0] mag;
	logic last_cell;

	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	assign row_c = idx_q[ADDR_W-1:COORD_W];
	assign col_c = idx_q[COORD_W-1:0];
	assign last_cell = (idx_q == ADDR_MAX) && (phase_q == 3'd4);

	always_comb begin
		nb_addr = idx_q;
		nb_ok = 1'b0;
		case (phase_q)
			3'd0: begin
				nb_addr = {row_c - COORD_W'(1), col_c};
				nb_ok = row_c != '0;
			end
			3'd1: begin
				nb_addr = {row_c + COORD_W'(1), col_c};
				nb_ok = row_c != COORD_MAX;
			end
			3'd2: begin
				nb_addr = {row_c, col_c - COORD_W'(1)};
				nb_ok = col_c != '0;
			end
			3'd3: begin
				nb_addr = {row_c, col_c + COORD_W'(1)};
				nb_ok = col_c != COORD_MAX;
			end
			default: begin
				nb_addr = idx_q;
				nb_ok = 1'b0;
			end
		endcase
	end

	assign cur_raddr = (state_q == ST_STEP) ? nb_addr : {in_ch.row, in_ch.col};
	assign cur_rdata = sel_q ? b_rdata : a_rdata;
	assign old_rdata = sel_q ? a_rdata : b_rdata;

	assign term = take_s1 ? ACC_W'(cur_rdata) : '0;
	assign sum_w = acc_q + term;
	assign half_w = sum_w >>> 1;
	assign n_w = half_w - ACC_W'(old_q);
	assign nd_w = WIDE_W'(n_w) - WIDE_W'(n_w >>> shift_q);
	assign step_val = sat_height(nd_w);
	assign inj_val = sat_height(WIDE_W'(cur_rdata) + WIDE_W'(amount_q));
	assign mag = cur_rdata[H_W-1] ? -(H_W+1)'(cur_rdata) : (H_W+1)'(cur_rdata);

	assign cur_we = (state_q == ST_CLEAR) || ((state_q == ST_MEM) && (act_q == ACT_INJECT));
	assign cur_waddr = (state_q == ST_CLEAR) ? idx_q : addr_q;
	assign cur_wdata = (state_q == ST_CLEAR) ? '0 : inj_val;
	assign old_we = (state_q == ST_CLEAR) || ((state_q == ST_STEP) && (phase_q == 3'd4));
	assign old_waddr = idx_q;
	assign old_wdata = (state_q == ST_CLEAR) ? '0 : step_val;

	wrgs_ram u_grid_a (
		.clk(clk),
		.we(sel_q ? old_we : cur_we),
		.waddr(sel_q ? old_waddr : cur_waddr),
		.wdata(sel_q ? old_wdata : cur_wdata),
		.raddr(sel_q ? idx_q : cur_raddr),
		.rdata(a_rdata)
	);

	wrgs_ram u_grid_b (
		.clk(clk),
		.we(sel_q ? cur_we : old_we),
		.waddr(sel_q ? cur_waddr : old_waddr),
		.wdata(sel_q ? cur_wdata : old_wdata),
		.raddr(sel_q ? cur_raddr : idx_q),
		.rdata(b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sel_q <= 1'b0;
			idx_q <= '0;
			phase_q <= '0;
			shift_q <= SHIFT_RESET;
			limit_q <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_DAMPING_SHIFT) begin
					shift_q <= cfg.data[SHIFT_W-1:0];
				end else if (cfg.index == REG_VISIBLE_LIMIT) begin
					limit_q <= cfg.data;
				end
			end
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (idx_q == ADDR_MAX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.action) inside
							ACT_STEP: begin
								state_q <= ST_STEP;
								idx_q <= '0;
								phase_q <= '0;
							end
							ACT_INJECT, ACT_READ: begin
								state_q <= ST_MEM;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_STEP: begin
					if (phase_q == 3'd4) begin
						phase_q <= '0;
						idx_q <= idx_q + ADDR_W'(1);
						if (last_cell) begin
							sel_q <= !sel_q;
							out_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_MEM: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		take_s1 <= nb_ok;
		if (state_q == ST_STEP) begin
			if (phase_q == 3'd1) begin
				acc_q <= term;
				old_q <= old_rdata;
			end else if (phase_q == 3'd2 || phase_q == 3'd3) begin
				acc_q <= sum_w;
			end
		end
		if (in_acc) begin
			act_q <= in_ch.action;
			addr_q <= {in_ch.row, in_ch.col};
			amount_q <= in_ch.amount;
			out_height_q <= '0;
			out_visible_q <= 1'b0;
			out_done_q <= 1'b0;
		end
		if (last_cell && state_q == ST_STEP) begin
			out_done_q <= 1'b1;
		end
		if (state_q == ST_MEM) begin
			out_done_q <= 1'b1;
			if (act_q == ACT_READ) begin
				out_height_q <= cur_rdata;
				out_visible_q <= mag < (H_W+1)'(limit_q);
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.height = out_height_q;
	assign out_ch.visible = out_visible_q;
	assign out_ch.done_res = out_done_q;

endmodule

`default_nettype wire

>>> rtl/core/wrgs_checker.sv
// Port-level checker of the water ripple block, bound to the top level.
// Depends on wrgs_pkg and the assertion macros header.
`default_nettype none
`include "water_ripple_grid_step_macros.svh"

module wrgs_checker import wrgs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire action_t in_action,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire height_t out_height
);

	logic in_beat;
	logic cell_beat;

	assign in_beat = in_valid && in_ready;
	assign cell_beat = in_beat && (in_action == ACT_INJECT || in_action == ACT_READ);

	// A new item is only taken when the result register can be freed.
	`WRGS_ASSERT_NOW(a_ready_needs_room, clk, arst_n, in_ready && out_valid, out_ready)
	// A cell access keeps the input closed for the following cycle.
	`WRGS_ASSERT_NEXT(a_cell_busy, clk, arst_n, cell_beat, !in_ready)
	// A cell access delivers its result beat after the registered grid read and the ST_MEM state.
	`WRGS_ASSERT_NOW(a_cell_latency, clk, arst_n, cell_beat, ##2 out_valid)
	// A stalled result beat holds its value.
	`WRGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_height))

endmodule

bind water_ripple_grid_step wrgs_checker u_wrgs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_action(in_ch.action),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_height(out_ch.height)
);

`default_nettype wire
